// ===== hw/rtl/mtdl_pkg.sv =====
// Shared types and constants for the multi-tap delay line.
// No dependencies.
`default_nettype none
package mtdl_pkg;

  localparam int NUM_TAPS  = 4;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    SRC_MEM  = 2'd0,
    SRC_CUR  = 2'd1,
    SRC_ZERO = 2'd2
  } tap_src_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mtdl_cfg.sv =====
// Tap delay registers with saturating writes.
// Depends on mtdl_pkg.
`default_nettype none
module mtdl_cfg
  import mtdl_pkg::*;
#(
  parameter int MAX_DELAY = 1023,
  parameter int DW        = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [CFG_IDX_W-1:0]          wr_idx,
  input  wire logic [DW-1:0]                 wr_data,
  output logic      [NUM_TAPS-1:0][DW-1:0]   delay
);

  logic [NUM_TAPS-1:0][DW-1:0] delay_r;
  logic [NUM_TAPS-1:0][DW-1:0] delay_nxt;
  logic [DW-1:0]               sat_val;

  assign sat_val = (wr_data > DW'(MAX_DELAY)) ? DW'(MAX_DELAY) : wr_data;

  always_comb begin
    delay_nxt = delay_r;
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (wr_en && (wr_idx == CFG_IDX_W'(k))) begin
        delay_nxt[k] = sat_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
    end else begin
      delay_r <= delay_nxt;
    end
  end

  assign delay = delay_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mtdl_tap_ram.sv =====
// One tap's copy of the sample memory: one write and one registered read
// per enabled cycle, with current-sample bypass and zero for unwritten reach.
// Depends on mtdl_pkg.
`default_nettype none
module mtdl_tap_ram
  import mtdl_pkg::*;
#(
  parameter int AW = 10,
  parameter int SW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [SW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  input  wire tap_src_t      src,
  output logic      [SW-1:0] tap
);

  localparam int DEPTH = 1 << AW;

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_r;
  logic [SW-1:0] cur_r;
  tap_src_t      src_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mem[waddr] <= wdata;
      rdata_r    <= mem[raddr];
      cur_r      <= wdata;
      src_r      <= src;
    end
  end

  always_comb begin
    unique case (src_r)
      SRC_MEM:  tap = rdata_r;
      SRC_CUR:  tap = cur_r;
      SRC_ZERO: tap = '0;
      default:  tap = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/multi_tap_delay_line.sv =====
// Multi-tap delay line with registered tap reads and outputs; one item per
// cycle while out_ready is high; each tap has its own copy of the sample
// memory, so one write and all tap reads fit in the same cycle.
// Reset clears the delays, write pointer and fill count; taps that reach
// past the samples seen since reset read zero, so no clearing pass runs.
// Depends on mtdl_pkg, mtdl_cfg, mtdl_tap_ram.
`default_nettype none
module multi_tap_delay_line
  import mtdl_pkg::*;
#(
  parameter int MAX_DELAY    = 1023,
  parameter int SAMPLE_WIDTH = 32,
  localparam int DEPTH       = MAX_DELAY + 1,
  localparam int AW          = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [AW-1:0]           cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0]      out_tap0_out,
  output logic [SAMPLE_WIDTH-1:0]      out_tap1_out,
  output logic [SAMPLE_WIDTH-1:0]      out_tap2_out,
  output logic [SAMPLE_WIDTH-1:0]      out_tap3_out
);

  localparam int RAM_AW = (AW > 0) ? AW : 1;

  logic [NUM_TAPS-1:0][AW-1:0]           delay;
  logic [NUM_TAPS-1:0][AW-1:0]           raddr;
  tap_src_t                              src [NUM_TAPS];
  logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] tap;
  logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] out_r;
  logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] out_nxt;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic          out_v_r, out_v_nxt;
  logic          accept;
  logic          s1_move;

  assign cfg_ready = 1'b1;

  mtdl_cfg #(
    .MAX_DELAY (MAX_DELAY),
    .DW        (AW)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_wdata),
    .delay   (delay)
  );

  assign s1_move  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || !out_v_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [AW:0] diff;
    for (int k = 0; k < NUM_TAPS; k++) begin
      diff = {1'b0, wp_r} - {1'b0, delay[k]};
      if (delay[k] > wp_r) begin
        diff = diff + (AW + 1)'(DEPTH);
      end
      raddr[k] = diff[AW-1:0];
      if (delay[k] == '0) begin
        src[k] = SRC_CUR;
      end else if (delay[k] > cnt_r) begin
        src[k] = SRC_ZERO;
      end else begin
        src[k] = SRC_MEM;
      end
    end
  end

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
    mtdl_tap_ram #(
      .AW (RAM_AW),
      .SW (SAMPLE_WIDTH)
    ) u_ram (
      .clk   (clk),
      .en    (accept),
      .waddr (wp_r),
      .wdata (in_sample_in),
      .raddr (raddr[g]),
      .src   (src[g]),
      .tap   (tap[g])
    );
  end

  always_comb begin
    wp_nxt    = wp_r;
    cnt_nxt   = cnt_r;
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (accept) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (cnt_r != AW'(MAX_DELAY)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (s1_move) begin
      out_v_nxt = 1'b1;
      out_nxt   = tap;
      s1_v_nxt  = 1'b0;
    end
    if (accept) begin
      s1_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid    = out_v_r;
  assign out_tap0_out = out_r[0];
  assign out_tap1_out = out_r[1];
  assign out_tap2_out = out_r[2];
  assign out_tap3_out = out_r[3];

endmodule
`default_nettype wire

// ===== tb/sv/multi_tap_delay_line_test.sv =====
// Self-checking testbench for multi_tap_delay_line: random stalls on both channels,
// tap delays loaded between phases, every tap result checked against a software delay line.
// Depends on mtdl_pkg and the multi_tap_delay_line RTL.
`default_nettype none
module multi_tap_delay_line_test;
  import mtdl_pkg::*;

  localparam int MAX_DELAY      = 1023;
  localparam int DEPTH          = MAX_DELAY + 1;
  localparam int AW             = $clog2(DEPTH);
  localparam int SW             = 32;
  localparam int PIPE_LATENCY   = 2;
  localparam int NUM_ITEMS      = 1450;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 300000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_TAP0 = 0,
    REG_DELAY_TAP1 = 1,
    REG_DELAY_TAP2 = 2,
    REG_DELAY_TAP3 = 3
  } delay_reg_t;

  typedef logic [NUM_TAPS-1:0][SW-1:0] tap_result_t;
  typedef logic [NUM_TAPS-1:0][AW-1:0] tap_delays_t;

  localparam logic [9:0][SW-1:0] DIRECTED_SAMPLES = {
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h1234_5678, 32'hFEDC_BA98
  };

  class tap_scoreboard;
    logic [SW-1:0] sample_mem [DEPTH];
    logic [AW-1:0] wr_ptr;
    logic [AW-1:0] tap_delay [NUM_TAPS];
    tap_result_t   expected_taps [$];
    int            failures;

    function new();
      for (int i = 0; i < DEPTH; i++) sample_mem[i] = '0;
      for (int k = 0; k < NUM_TAPS; k++) tap_delay[k] = '0;
      wr_ptr   = '0;
      failures = 0;
    endfunction

    function void set_delay(delay_reg_t idx, int value);
      if (int'(idx) >= NUM_TAPS) return;
      if (value > MAX_DELAY) value = MAX_DELAY;
      tap_delay[idx] = value[AW-1:0];
    endfunction

    function void note_sample(logic [SW-1:0] s);
      tap_result_t want;
      int          rd;
      sample_mem[wr_ptr] = s;
      for (int k = 0; k < NUM_TAPS; k++) begin
        rd = (int'(wr_ptr) + DEPTH - int'(tap_delay[k]) % DEPTH) % DEPTH;
        want[k] = sample_mem[rd];
      end
      expected_taps.push_back(want);
      wr_ptr = AW'((int'(wr_ptr) + 1) % DEPTH);
    endfunction

    function void check_result(tap_result_t got);
      tap_result_t want;
      if (expected_taps.size() == 0) begin
        $error("tap result with no sample pending");
        failures++;
        return;
      end
      want = expected_taps.pop_front();
      for (int k = 0; k < NUM_TAPS; k++) begin
        if (got[k] !== want[k]) begin
          $error("tap%0d_out: expected %h, actual %h", k, want[k], got[k]);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_taps.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [AW-1:0]        cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SW-1:0]        in_sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SW-1:0]        out_tap0_out;
  logic [SW-1:0]        out_tap1_out;
  logic [SW-1:0]        out_tap2_out;
  logic [SW-1:0]        out_tap3_out;

  tap_scoreboard sb;
  bit            hold_off_request = 1'b0;
  int            in_burst_left = 0;
  int            cycle_count = 0;

  multi_tap_delay_line #(
    .MAX_DELAY    (MAX_DELAY),
    .SAMPLE_WIDTH (SW)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_in (in_sample_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tap0_out (out_tap0_out),
    .out_tap1_out (out_tap1_out),
    .out_tap2_out (out_tap2_out),
    .out_tap3_out (out_tap3_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_tap3_out, out_tap2_out, out_tap1_out, out_tap0_out});
  end

  initial begin
    int gap;
    int out_burst_left;
    out_burst_left = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        gap = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end else if (out_burst_left > 0) begin
        gap = 0;
        out_burst_left--;
      end else begin
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) out_burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic drain_taps();
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic load_delays(input tap_delays_t d);
    drain_taps();
    for (int k = 0; k < NUM_TAPS; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= delay_reg_t'(k);
      cfg_wdata <= d[k];
      do @(posedge clk); while (!cfg_ready);
      sb.set_delay(delay_reg_t'(k), int'(d[k]));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [SW-1:0] s);
    int gap;
    if (in_burst_left > 0) begin
      gap = 0;
      in_burst_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) in_burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  initial begin
    tap_delays_t   d;
    logic [SW-1:0] s;
    int            total;
    int            len;
    int            phase_no;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset delays are zero: each tap returns the current item
    for (int i = 0; i < 2; i++) send_sample(DIRECTED_SAMPLES[i]);
    in_valid <= 1'b0;

    // longest tap reaches before the first item and reads zero
    load_delays({AW'(MAX_DELAY), AW'(2), AW'(1), AW'(0)});
    for (int i = 2; i < 10; i++) send_sample(DIRECTED_SAMPLES[i]);
    in_valid <= 1'b0;

    load_delays({AW'(MAX_DELAY - 1), AW'(MAX_DELAY), AW'(5), AW'(MAX_DELAY)});
    for (int i = 0; i < 10; i++) send_sample($urandom);
    in_valid <= 1'b0;

    total    = 20;
    phase_no = 0;
    while (total < NUM_ITEMS) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        case ($urandom_range(0, 5))
          0:       d[k] = '0;
          1:       d[k] = AW'(1);
          2:       d[k] = AW'(MAX_DELAY);
          3:       d[k] = AW'(MAX_DELAY - 1);
          4:       d[k] = AW'($urandom_range(2, 64));
          default: d[k] = AW'($urandom_range(0, MAX_DELAY));
        endcase
        if (phase_no == 2) d[k] = AW'(MAX_DELAY);
        if (phase_no == 3) d[k] = '0;
      end
      load_delays(d);
      len = $urandom_range(40, 120);
      if (phase_no == 1 || phase_no == 6) begin
        len = 160;
        hold_off_request = 1'b1;
      end
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       s = '0;
          1:       s = '1;
          2:       s = SW'(1) << $urandom_range(0, SW - 1);
          default: s = $urandom;
        endcase
        send_sample(s);
      end
      in_valid <= 1'b0;
      total += len;
      phase_no++;
    end

    drain_taps();
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/mtdl_pkg.sv
hw/rtl/mtdl_cfg.sv
hw/rtl/mtdl_tap_ram.sv
hw/rtl/multi_tap_delay_line.sv
tb/sv/multi_tap_delay_line_test.sv
